// ===== design/vtpd_pkg.sv =====
package vtpd_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_IDX_W = 8;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = 48;
    localparam int SUM_W     = 50;

    localparam logic MODE_POINT = 1'b0;
    localparam logic MODE_VEC4  = 1'b1;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

    // Row sums of one vertex, clamped to 32 bits
    typedef struct packed {
        logic             mode;
        logic             sat;
        logic [3:0][31:0] r;
    } rowsum_t;

    // One divider pipeline stage: three lanes share the divisor |w|
    typedef struct packed {
        rowsum_t          rs;
        logic [31:0]      dvsr;
        logic [2:0][47:0] nq;
        logic [2:0][31:0] rem;
    } div_stage_t;

    function automatic logic [63:0] cfg_reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [63:0] v;
        v = 64'd0;
        case (idx)
            3'd0:    v = 64'h0000_0000_0001_0000;
            3'd2:    v = 64'h0001_0000_0000_0000;
            3'd5:    v = 64'h0000_0000_0001_0000;
            3'd7:    v = 64'h0001_0000_0000_0000;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/vtpd_front.sv =====
module vtpd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic signed [31:0]             in_x,
    input  logic signed [31:0]             in_y,
    input  logic signed [31:0]             in_z,
    input  logic signed [31:0]             in_w,
    input  logic                           q_full,
    output logic                           push,
    output vtpd_pkg::rowsum_t              push_data
);
    import vtpd_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(Q_MIN);

    logic [63:0]              mat_reg [NUM_REGS];
    logic signed [31:0]       elem [4][4];
    logic signed [31:0]       vec [4];
    logic signed [63:0]       prod_reg [4][4];
    logic                     mode1_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    rowsum_t                  rs_reg;
    rowsum_t                  rs_next;
    logic signed [SUM_W-1:0]  sum [4];
    logic                     en;

    assign en       = !q_full;
    assign in_ready = en;
    assign push     = en && v2_reg;
    assign push_data = rs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mat_reg[i] <= cfg_reset_value(REG_IDX_W'(i));
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            mat_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                elem[r][c] = r[0] ? mat_reg[c * 2 + r / 2][63:32]
                                  : mat_reg[c * 2 + r / 2][31:0];
            end
        end
        vec[0] = in_x;
        vec[1] = in_y;
        vec[2] = in_z;
        vec[3] = (mode == MODE_POINT) ? ONE_Q16 : in_w;
    end

    // Stage 1: sixteen products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= elem[r][c] * vec[c];
                end
            end
            mode1_reg <= mode;
        end
    end

    // Stage 2: floor each product, sum the row, clamp
    always_comb
    begin
        rs_next      = '0;
        rs_next.mode = mode1_reg;
        for (int r = 0; r < 4; r++)
        begin
            sum[r] = SUM_W'(prod_reg[r][0] >>> FRAC_W) + SUM_W'(prod_reg[r][1] >>> FRAC_W)
                   + SUM_W'(prod_reg[r][2] >>> FRAC_W) + SUM_W'(prod_reg[r][3] >>> FRAC_W);
            if (sum[r] > SUM_MAX)
            begin
                rs_next.r[r] = Q_MAX;
                rs_next.sat  = 1'b1;
            end
            else if (sum[r] < SUM_MIN)
            begin
                rs_next.r[r] = Q_MIN;
                rs_next.sat  = 1'b1;
            end
            else
            begin
                rs_next.r[r] = sum[r][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_reg <= rs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

endmodule

// ===== design/vtpd_queue.sv =====
module vtpd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vtpd_pkg::rowsum_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output vtpd_pkg::rowsum_t pop_data
);
    import vtpd_pkg::*;

    rowsum_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/vtpd_back.sv =====
module vtpd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  vtpd_pkg::rowsum_t   q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic signed [31:0]  out_w,
    output logic                w_zero,
    output logic                saturated
);
    import vtpd_pkg::*;

    div_stage_t          stg_reg [QUO_W + 1];
    logic                vld_reg [QUO_W + 1];
    div_stage_t          setup;
    div_stage_t          last;
    logic                en;
    logic                out_valid_reg;
    logic [3:0][31:0]    res_next;
    logic                wz_next;
    logic                sat_next;
    logic [3:0][31:0]    res_reg;
    logic                wz_reg;
    logic                sat_reg;
    logic                neg;

    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t o;
        logic [32:0] t;
        o = s;
        for (int i = 0; i < 3; i++)
        begin
            t = {s.rem[i], s.nq[i][QUO_W-1]};
            if (t >= {1'b0, s.dvsr})
            begin
                o.rem[i] = 32'(t - {1'b0, s.dvsr});
                o.nq[i]  = {s.nq[i][QUO_W-2:0], 1'b1};
            end
            else
            begin
                o.rem[i] = t[31:0];
                o.nq[i]  = {s.nq[i][QUO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && q_not_empty;
    assign out_valid = out_valid_reg;

    // Magnitudes for the unsigned restoring divide
    always_comb
    begin
        setup      = '0;
        setup.rs   = q_data;
        setup.dvsr = q_data.r[3][31] ? (32'd0 - q_data.r[3]) : q_data.r[3];
        for (int i = 0; i < 3; i++)
        begin
            setup.nq[i] = {(q_data.r[i][31] ? (32'd0 - q_data.r[i]) : q_data.r[i]),
                           FRAC_W'(0)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= setup;
            for (int k = 1; k <= QUO_W; k++)
            begin
                stg_reg[k] <= div_step(stg_reg[k-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUO_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= q_not_empty;
            for (int k = 1; k <= QUO_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[QUO_W];
        end
    end

    // Sign, zero-w handling and clamp of the quotients in point mode; vec4 row sums pass through
    always_comb
    begin
        last     = stg_reg[QUO_W];
        res_next = last.rs.r;
        sat_next = last.rs.sat;
        wz_next  = (last.rs.mode == MODE_POINT) && (last.rs.r[3] == '0);
        neg      = 1'b0;
        if (last.rs.mode == MODE_POINT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg = last.rs.r[i][31] ^ last.rs.r[3][31];
                if (wz_next)
                begin
                    if (last.rs.r[i] == '0)
                    begin
                        res_next[i] = '0;
                    end
                    else
                    begin
                        res_next[i] = last.rs.r[i][31] ? Q_MIN : Q_MAX;
                        sat_next    = 1'b1;
                    end
                end
                else if (!neg)
                begin
                    if (last.nq[i] > QUO_W'(Q_MAX))
                    begin
                        res_next[i] = Q_MAX;
                        sat_next    = 1'b1;
                    end
                    else
                    begin
                        res_next[i] = last.nq[i][31:0];
                    end
                end
                else
                begin
                    if (last.nq[i] > {16'd0, 32'h8000_0000})
                    begin
                        res_next[i] = Q_MIN;
                        sat_next    = 1'b1;
                    end
                    else
                    begin
                        res_next[i] = 32'd0 - last.nq[i][31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            wz_reg  <= wz_next;
            sat_reg <= sat_next;
        end
    end

    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_w     = res_reg[3];
    assign w_zero    = wz_reg;
    assign saturated = sat_reg;

endmodule

// ===== design/vertex_transform_perspective_divide_core.sv =====
// Vertex transform: 4x4 Q16.16 matrix times one vector per request, with an
// optional perspective divide by the fourth-row result.
// Channels: the configuration channel writes one 64-bit matrix register per
// request (two elements of one column); it is always ready. The input channel
// takes mode and x, y, z, w; the output channel returns x, y, z, w and the
// w_zero and saturated flags, one result per input, in order.
// Throughput: one vertex per cycle when nothing stalls. An input passes the
// product and row-sum registers, the queue, the divider input register, a
// 48-step restoring divider with one quotient bit per stage, and the output
// register.
// A 4-entry queue sits between the multiply front and the divider back end.
// With out_valid high and out_ready held low the divider pipeline holds; the
// front keeps taking requests until the queue fills, then drops in_ready.
// Reset clears all valid state and loads the identity matrix. Write the matrix
// only while no requests are in flight.
module vertex_transform_perspective_divide_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic signed [31:0]             in_x,
    input  logic signed [31:0]             in_y,
    input  logic signed [31:0]             in_z,
    input  logic signed [31:0]             in_w,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             out_x,
    output logic signed [31:0]             out_y,
    output logic signed [31:0]             out_z,
    output logic signed [31:0]             out_w,
    output logic                           w_zero,
    output logic                           saturated
);
    import vtpd_pkg::*;

    logic    q_full;
    logic    push;
    rowsum_t push_data;
    logic    pop;
    logic    q_not_empty;
    rowsum_t q_data;

    assign cfg_ready = 1'b1;

    vtpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_w      (in_w),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    vtpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    vtpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w),
        .w_zero      (w_zero),
        .saturated   (saturated)
    );

endmodule

// ===== tb/sv/vertex_transform_perspective_divide_core_tb.sv =====
module vertex_transform_perspective_divide_core_tb;
    import vtpd_pkg::*;

    typedef struct {
        logic        mode;
        logic [31:0] x, y, z, w;
    } vertex_t;

    typedef struct {
        logic [31:0] x, y, z, w;
        logic        wz, sat;
    } xform_t;

    class vertex_scoreboard;
        logic [63:0] matrix [NUM_REGS];
        xform_t      pending [$];
        int          errors;

        function new();
            errors = 0;
            for (int i = 0; i < NUM_REGS; i++) matrix[i] = cfg_reset_value(i[REG_IDX_W-1:0]);
        endfunction

        function void write_reg(int idx, logic [63:0] data);
            if (idx < NUM_REGS) matrix[idx] = data;
        endfunction

        function longint element(int row, int col);
            logic [63:0] r;
            r = matrix[col * 2 + row / 2];
            return (row % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
        endfunction

        function longint clamp(longint v, ref bit sat);
            if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
            return v;
        endfunction

        function void note_vertex(vertex_t v);
            longint vec [4];
            longint rs [4];
            longint q;
            longint acc;
            longint prod;
            xform_t e;
            bit sat;
            bit pt;
            logic [31:0] res [3];
            sat = 0;
            pt = (v.mode == MODE_POINT);
            vec[0] = $signed(v.x);
            vec[1] = $signed(v.y);
            vec[2] = $signed(v.z);
            vec[3] = pt ? 64'sd65536 : longint'($signed(v.w));
            for (int r = 0; r < 4; r++)
            begin
                acc = 0;
                for (int c = 0; c < 4; c++)
                begin
                    prod = element(r, c) * vec[c];
                    acc += prod >>> 16;
                end
                rs[r] = clamp(acc, sat);
            end
            e.wz = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (!pt) res[i] = 32'(rs[i]);
                else if (rs[3] == 0)
                begin
                    e.wz = 1;
                    if (rs[i] > 0) begin res[i] = 32'h7FFFFFFF; sat = 1; end
                    else if (rs[i] < 0) begin res[i] = 32'h80000000; sat = 1; end
                    else res[i] = 0;
                end
                else
                begin
                    // operands fit in 48 bits, so the quotient truncates toward zero
                    q = (rs[i] * 64'sd65536) / rs[3];
                    res[i] = 32'(clamp(q, sat));
                end
            end
            e.x = res[0];
            e.y = res[1];
            e.z = res[2];
            e.w = 32'(rs[3]);
            e.sat = sat;
            pending.push_back(e);
        endfunction

        function void check_result(xform_t a);
            xform_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result x=%h", a.x);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.x !== e.x) begin $error("out_x exp %h got %h", e.x, a.x); errors++; end
            if (a.y !== e.y) begin $error("out_y exp %h got %h", e.y, a.y); errors++; end
            if (a.z !== e.z) begin $error("out_z exp %h got %h", e.z, a.z); errors++; end
            if (a.w !== e.w) begin $error("out_w exp %h got %h", e.w, a.w); errors++; end
            if (a.wz !== e.wz) begin $error("w_zero exp %b got %b", e.wz, a.wz); errors++; end
            if (a.sat !== e.sat)
            begin
                $error("saturated exp %b got %b", e.sat, a.sat);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;
    logic in_valid, in_ready, mode;
    logic signed [31:0] in_x, in_y, in_z, in_w;
    logic out_valid, out_ready;
    logic signed [31:0] out_x, out_y, out_z, out_w;
    logic w_zero, saturated;

    vertex_transform_perspective_divide_core DUT (.*);

    vertex_scoreboard sb;
    int idle_cycles;
    int hold_off;
    bit stim_done;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        mode = 0;
        in_x = 0;
        in_y = 0;
        in_z = 0;
        in_w = 0;
        out_ready = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
    end

    function logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h00010000;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return 0;
            4: return $urandom;
            default: return $signed($urandom_range(0, 32'h6FFFF)) - 32'sh38000;
        endcase
    endfunction

    function logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
        endcase
    endfunction

    // leave cfg_valid high; end_config drops it after the last write
    task automatic write_reg(int idx, logic [63:0] data);
        cfg_valid <= 1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic end_config();
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // hold in_valid high across back-to-back requests
    task automatic send_vertex(vertex_t v, bit keep);
        in_valid <= 1;
        mode <= v.mode;
        in_x <= v.x;
        in_y <= v.y;
        in_z <= v.z;
        in_w <= v.w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_vertex(v);
        if (!keep) in_valid <= 0;
    endtask

    task automatic send_burst(int n, bit gaps);
        vertex_t v;
        int burst;
        int gap;
        while (n > 0)
        begin
            burst = gaps ? $urandom_range(1, 12) : n;
            if (burst > n) burst = n;
            gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            for (int i = 0; i < burst; i++)
            begin
                v.mode = 1'($urandom_range(0, 1));
                v.x = rand_comp();
                v.y = rand_comp();
                v.z = rand_comp();
                v.w = rand_comp();
                send_vertex(v, (i != burst - 1) || (gap == 0 && n > burst));
            end
            n -= burst;
            if (gap > 0) repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_matrix(int kind);
        logic [31:0] lo, hi;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (kind)
                0: write_reg(i, cfg_reset_value(i[REG_IDX_W-1:0]));
                1: write_reg(i, 64'h7FFFFFFF_7FFFFFFF);
                2: write_reg(i, 64'h80000000_80000000);
                3: write_reg(i, 64'h0);
                default:
                begin
                    lo = rand_elem();
                    hi = rand_elem();
                    write_reg(i, {hi, lo});
                end
            endcase
        end
    endtask

    initial
    begin
        vertex_t v;
        sb = new();
        stim_done = 0;
        hold_off = 0;
        @(posedge rst_n);
        @(posedge clk);
        // directed: identity, extremes, zero w, both modes
        for (int i = 0; i < 12; i++)
        begin
            v.mode = i[0];
            case (i / 2)
                0: begin v.x = 32'h7FFFFFFF; v.y = 32'h80000000; v.z = 0; v.w = 32'h7FFFFFFF; end
                1: begin v.x = 32'h80000000; v.y = 32'h7FFFFFFF; v.z = 32'hFFFFFFFF; v.w = 0; end
                2: begin v.x = 32'h00010000; v.y = 32'hFFFF0000; v.z = 1; v.w = 32'h80000000; end
                3: begin v.x = 0; v.y = 0; v.z = 0; v.w = 0; end
                4: begin v.x = 32'hFFFFFFFF; v.y = 32'h55555555; v.z = 32'hAAAAAAAA; v.w = 1; end
                default:
                begin
                    v.x = 32'h00030000; v.y = 32'hFFFD0000;
                    v.z = 32'h7FFF0000; v.w = 32'h00020000;
                end
            endcase
            send_vertex(v, i != 11);
        end
        drain();
        // a zero last row gives w of zero in point mode
        load_matrix(3);
        write_reg(0, 64'h00000000_00020000);
        write_reg(2, 64'hFFFF0000_00000000);
        write_reg(8, 64'hDEAD);
        end_config();
        send_burst(6, 0);
        drain();
        load_matrix(1);
        end_config();
        send_burst(6, 0);
        drain();
        load_matrix(2);
        end_config();
        send_burst(6, 0);
        drain();
        // pressure: long receiver hold-off while requests keep coming
        load_matrix(0);
        end_config();
        hold_off = 200;
        send_burst(120, 0);
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            load_matrix(ph % 6 == 0 ? 0 : 4);
            end_config();
            send_burst(138, 1);
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 0;
                hold_off--;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: out_ready <= ($urandom_range(0, 3) != 0);
                    1: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= 1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        xform_t a;
        if (rst_n && out_valid && out_ready)
        begin
            a.x = out_x;
            a.y = out_y;
            a.z = out_z;
            a.w = out_w;
            a.wz = w_zero;
            a.sat = saturated;
            sb.check_result(a);
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stim_done)
            begin
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("Regression PASS");
                else
                    $display("Regression FAIL");
                $finish;
            end
            if (idle_cycles > 5000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
